// ===== hw/rtl/lfr_pkg.sv =====
// ---------------------------------------------------------------------------
// lfr_pkg: shared types and constants for the letter frequency ranking
// Bin layout, ASCII anchors and the command/status bundles between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package lfr_pkg;

    localparam int NUM_BINS  = 52;
    localparam int HALF_BINS = 26;
    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int OUT_CNT_W = 8;
    localparam int CHAR_W    = 8;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    // Controller to datapath
    typedef struct packed {
        logic load;        // count the accepted character
        logic scan_start;  // restart a max-search pass over the bins
        logic emit;        // push the pass winner to the output register
        logic emit_empty;  // push the empty report
    } lfr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic none_left;   // no nonzero bin remains
        logic last_left;   // exactly one nonzero bin remains
        logic pass_busy;   // search pass still reading or comparing
        logic out_free;    // output register can take a beat this cycle
    } lfr_status_t;

endpackage

// ===== hw/rtl/lfr_ctrl.sv =====
// ---------------------------------------------------------------------------
// lfr_ctrl: sequencer for the letter frequency ranking
// Accepts characters, waits for the last count to land, then runs one
// max-search pass per reported letter and hands each winner, or the empty report, to the output.
// ---------------------------------------------------------------------------
module lfr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  lfr_pkg::lfr_status_t st,
    output lfr_pkg::lfr_cmd_t    cmd
);
    import lfr_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_fire;

    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.load       = in_fire;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && in_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                if (st.none_left)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!st.pass_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = st.last_left ? ST_LOAD : ST_START;
                end
            end
            ST_EMPTY:
            begin
                if (st.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/lfr_dp.sv =====
// ---------------------------------------------------------------------------
// lfr_dp: bin memory, increment pipeline, max search and output register
// Bins live in a one-write, one-read memory with a valid bit per entry;
// an invalid entry reads as zero, so clearing a bin is dropping its bit.
// ---------------------------------------------------------------------------
module lfr_dp #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lfr_pkg::lfr_cmd_t            cmd,
    output lfr_pkg::lfr_status_t         st,
    input  logic [lfr_pkg::CHAR_W-1:0]   char_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lfr_pkg::CHAR_W-1:0]   out_letter,
    output logic [lfr_pkg::OUT_CNT_W-1:0] out_count,
    output logic                         out_last
);
    import lfr_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam int                     NZ_W      = $clog2(NUM_BINS + 1);
    localparam int                     EXT_W     = COUNT_WIDTH + OUT_CNT_W;

    logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
    logic [NUM_BINS-1:0]    bin_valid_reg;

    logic                   in_letter;
    logic [BIN_W-1:0]       in_bin;
    logic [BIN_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;

    logic                   ld_v_reg;
    logic [BIN_W-1:0]       ld_bin_reg;
    logic                   fwd_v_reg;
    logic [BIN_W-1:0]       fwd_bin_reg;
    logic [COUNT_WIDTH-1:0] fwd_val_reg;
    logic [COUNT_WIDTH-1:0] cur_val;
    logic [COUNT_WIDTH-1:0] inc_val;
    logic [COUNT_WIDTH-1:0] rd_val;

    logic [NZ_W-1:0]        nz_cnt_reg;

    logic                   scan_run_reg;
    logic [BIN_W-1:0]       scan_idx_reg;
    logic                   cmp_v_reg;
    logic [BIN_W-1:0]       cmp_bin_reg;
    logic                   best_v_reg;
    logic [BIN_W-1:0]       best_bin_reg;
    logic [COUNT_WIDTH-1:0] best_cnt_reg;

    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      out_letter_reg;
    logic [OUT_CNT_W-1:0]   out_count_reg;
    logic                   out_last_reg;
    logic [CHAR_W-1:0]      best_code;
    logic [OUT_CNT_W-1:0]   best_sat;
    logic [EXT_W-1:0]       best_ext;

    // Map a character to its bin
    always_comb
    begin
        in_letter = 1'b0;
        in_bin    = '0;
        if (char_byte >= CHAR_UPPER_A && char_byte <= CHAR_UPPER_Z)
        begin
            in_letter = 1'b1;
            in_bin    = BIN_W'(char_byte - CHAR_UPPER_A);
        end
        else if (char_byte >= CHAR_LOWER_A && char_byte <= CHAR_LOWER_Z)
        begin
            in_letter = 1'b1;
            in_bin    = BIN_W'(char_byte - CHAR_LOWER_A) + BIN_W'(HALF_BINS);
        end
    end

    assign rd_addr = scan_run_reg ? scan_idx_reg : in_bin;

    // Current bin value, forwarding the write that just landed
    assign rd_val  = rd_valid_reg ? rd_data_reg : '0;
    assign cur_val = (fwd_v_reg && fwd_bin_reg == ld_bin_reg) ? fwd_val_reg : rd_val;
    assign inc_val = (cur_val == COUNT_MAX) ? cur_val : cur_val + 1'b1;

    // Bin memory: one read, one write per cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (ld_v_reg)
        begin
            mem[ld_bin_reg] <= inc_val;
        end
    end

    // Payload side of the load pipeline
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= bin_valid_reg[rd_addr];
        ld_bin_reg   <= in_bin;
        fwd_bin_reg  <= ld_bin_reg;
        fwd_val_reg  <= inc_val;
        cmp_bin_reg  <= scan_idx_reg;
    end

    // Valid bits, nonzero-bin count and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            nz_cnt_reg    <= '0;
            ld_v_reg      <= 1'b0;
            fwd_v_reg     <= 1'b0;
        end
        else
        begin
            ld_v_reg  <= cmd.load && in_letter;
            fwd_v_reg <= ld_v_reg;
            if (ld_v_reg)
            begin
                bin_valid_reg[ld_bin_reg] <= 1'b1;
                if (cur_val == '0)
                begin
                    nz_cnt_reg <= nz_cnt_reg + 1'b1;
                end
            end
            else if (cmd.emit)
            begin
                bin_valid_reg[best_bin_reg] <= 1'b0;
                nz_cnt_reg                  <= nz_cnt_reg - 1'b1;
            end
        end
    end

    // Max-search pass: strict compare keeps the lowest bin on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_run_reg <= 1'b0;
            scan_idx_reg <= '0;
            cmp_v_reg    <= 1'b0;
            best_v_reg   <= 1'b0;
        end
        else
        begin
            cmp_v_reg <= scan_run_reg;
            if (cmd.scan_start)
            begin
                scan_run_reg <= 1'b1;
                scan_idx_reg <= '0;
                best_v_reg   <= 1'b0;
            end
            else
            begin
                if (scan_run_reg)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    if (scan_idx_reg == BIN_W'(NUM_BINS - 1))
                    begin
                        scan_run_reg <= 1'b0;
                    end
                end
                if (cmp_v_reg && rd_valid_reg &&
                    (!best_v_reg || rd_data_reg > best_cnt_reg))
                begin
                    best_v_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd.scan_start && cmp_v_reg && rd_valid_reg &&
            (!best_v_reg || rd_data_reg > best_cnt_reg))
        begin
            best_bin_reg <= cmp_bin_reg;
            best_cnt_reg <= rd_data_reg;
        end
    end

    // Letter code and reported count of the winner
    assign best_code = (best_bin_reg < BIN_W'(HALF_BINS))
                     ? CHAR_UPPER_A + CHAR_W'(best_bin_reg)
                     : CHAR_LOWER_A + CHAR_W'(best_bin_reg - BIN_W'(HALF_BINS));
    assign best_ext  = EXT_W'(best_cnt_reg);
    assign best_sat  = (best_ext > EXT_W'(255)) ? '1 : best_ext[OUT_CNT_W-1:0];

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.emit_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_letter_reg <= best_code;
            out_count_reg  <= best_sat;
            out_last_reg   <= (nz_cnt_reg == NZ_W'(1));
        end
        else if (cmd.emit_empty)
        begin
            out_letter_reg <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_letter = out_letter_reg;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;

    // Status to the controller
    assign st.none_left = (nz_cnt_reg == '0);
    assign st.last_left = (nz_cnt_reg == NZ_W'(1));
    assign st.pass_busy = scan_run_reg || cmp_v_reg;
    assign st.out_free  = !out_valid_reg || out_ready;

endmodule

// ===== hw/rtl/letter_frequency_ranking.sv =====
// ---------------------------------------------------------------------------
// letter_frequency_ranking: letter histogram reported by falling count
// Counts A-Z and a-z in 52 saturating bins and, on the last character,
// streams one beat per nonzero bin, count descending then code ascending.
// ---------------------------------------------------------------------------
// Characters are taken one per cycle while the block is loading. The beat
// with tlast set is counted, then input stalls for the ranking: each
// reported letter costs one search pass over the bin memory, which has a
// single read port, so each letter waits for a pass over all NUM_BINS
// bins plus any output stall; a drain state lets the last count land
// first, ahead of the first pass. A text with no letters yields one
// beat with letter 0, count 0 and tlast set. Bins are empty again when the
// last beat is handed to the output register, and the next text may start
// while that beat waits. Counts wider than 8 bits report as 255 when above.
module letter_frequency_ranking #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] letter, [15:8] letter_count
    output logic        m_axis_tlast    // last_of_run
);
    import lfr_pkg::*;

    lfr_cmd_t             cmd;
    lfr_status_t          st;
    logic [CHAR_W-1:0]    out_letter;
    logic [OUT_CNT_W-1:0] out_count;

    lfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lfr_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .char_byte  (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_letter (out_letter),
        .out_count  (out_count),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_count, out_letter};

endmodule

// ===== hw/rtl/lfr_checker.sv =====
// ---------------------------------------------------------------------------
// lfr_checker: port-level checks for the letter frequency ranking
// Watches both stream groups and flags beats that break the ranking rules.
// ---------------------------------------------------------------------------
module lfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // Stop taking characters once the closing one is in
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted during ranking");

    // A zero count only appears as the empty report
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[15:8] == 8'd0 |->
            m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
        else $error("zero count outside the empty report");

    // A reported code is a letter
    a_letter: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[15:8] != 8'd0 |->
            (m_axis_tdata[7:0] >= 8'h41 && m_axis_tdata[7:0] <= 8'h5A) ||
            (m_axis_tdata[7:0] >= 8'h61 && m_axis_tdata[7:0] <= 8'h7A))
        else $error("reported code is not a letter");

endmodule

bind letter_frequency_ranking lfr_checker u_lfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/letter_frequency_ranking_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// letter_frequency_ranking_tb: self-checking bench for the letter ranking
// Streams texts into the block and compares every ranking beat against a
// behavioral histogram that sorts by count, then by letter code. A short
// table of edge cases runs first. Random texts follow under several idling
// mixes, and one long output hold-off forces the input side to stall.
// ---------------------------------------------------------------------------
module letter_frequency_ranking_tb;

    import lfr_pkg::*;

    localparam int CNT_W          = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT    = 5000;
    localparam int PHASE_CHARS    = 35;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // One ranking beat as it leaves the block
    typedef struct packed {
        logic [7:0] letter;
        logic [7:0] count;
        logic       closing;
    } rank_beat_t;

    // One directed row; the character repeats, the flag goes on the last copy
    typedef struct packed {
        logic [7:0]  ch;
        logic        text_end;
        logic [15:0] reps;
        logic        typed;
        rank_beat_t  want;
    } char_row_t;

    localparam int NUM_ROWS = 18;
    localparam char_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // no letters: all-zero byte, all-ones byte, bytes just outside ranges
        '{8'h00, 1'b1, 16'd1,   1'b1, '{8'h00, 8'd0,   1'b1}},
        '{8'hFF, 1'b1, 16'd1,   1'b1, '{8'h00, 8'd0,   1'b1}},
        '{8'h40, 1'b0, 16'd1,   1'b0, '{8'h00, 8'd0,   1'b0}},
        '{8'h5B, 1'b0, 16'd1,   1'b0, '{8'h00, 8'd0,   1'b0}},
        '{8'h60, 1'b0, 16'd1,   1'b0, '{8'h00, 8'd0,   1'b0}},
        '{8'h7B, 1'b1, 16'd1,   1'b1, '{8'h00, 8'd0,   1'b1}},
        // single letter counted on the closing beat
        '{8'h41, 1'b1, 16'd1,   1'b1, '{8'h41, 8'd1,   1'b1}},
        // range ends, all tied
        '{8'h5A, 1'b0, 16'd1,   1'b0, '{8'h00, 8'd0,   1'b0}},
        '{8'h7A, 1'b0, 16'd1,   1'b0, '{8'h00, 8'd0,   1'b0}},
        '{8'h61, 1'b1, 16'd1,   1'b0, '{8'h00, 8'd0,   1'b0}},
        // case kept apart
        '{8'h62, 1'b0, 16'd2,   1'b0, '{8'h00, 8'd0,   1'b0}},
        '{8'h42, 1'b0, 16'd1,   1'b0, '{8'h00, 8'd0,   1'b0}},
        '{8'h6D, 1'b1, 16'd1,   1'b0, '{8'h00, 8'd0,   1'b0}},
        // a run of one letter, back to back into the same bin
        '{8'h7A, 1'b0, 16'd9,   1'b0, '{8'h00, 8'd0,   1'b0}},
        '{8'h7A, 1'b1, 16'd1,   1'b1, '{8'h7A, 8'd10,  1'b1}},
        // tie between upper and lower case at a higher count
        '{8'h51, 1'b0, 16'd3,   1'b0, '{8'h00, 8'd0,   1'b0}},
        '{8'h71, 1'b0, 16'd3,   1'b0, '{8'h00, 8'd0,   1'b0}},
        '{8'h41, 1'b1, 16'd1,   1'b0, '{8'h00, 8'd0,   1'b0}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] char_byte
    logic        s_axis_tlast = 1'b0;     // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [7:0] letter, [15:8] letter_count
    logic        m_axis_tlast;            // last_of_run

    logic [CNT_W-1:0] letter_tally [NUM_BINS];
    rank_beat_t       fresh_ranking [$];
    rank_beat_t       pending_ranking [$];
    int               mismatches = 0;
    int               chars_sent = 0;
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    bit               hold_off_req = 1'b0;

    letter_frequency_ranking #(
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // Count one character; on the closing one, build the ranking and clear
    function automatic void tally_char(input logic [7:0] c, input logic text_end);
        int         bin;
        int         best;
        logic [NUM_BINS-1:0] taken;
        rank_beat_t beat;

        fresh_ranking.delete();
        bin = -1;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            bin = int'(c - CHAR_UPPER_A);
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            bin = HALF_BINS + int'(c - CHAR_LOWER_A);
        if (bin >= 0 && letter_tally[bin] != CNT_MAX)
            letter_tally[bin] = letter_tally[bin] + 1'b1;
        if (!text_end)
            return;

        // pick the largest remaining bin; bin order is letter code order
        taken = '0;
        do
        begin
            best = -1;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                if (!taken[i] && letter_tally[i] != 0 &&
                    (best < 0 || letter_tally[i] > letter_tally[best]))
                    best = i;
            end
            if (best >= 0)
            begin
                taken[best] = 1'b1;
                beat.letter = (best < HALF_BINS) ? 8'(CHAR_UPPER_A + best)
                                                 : 8'(CHAR_LOWER_A + best - HALF_BINS);
                beat.count = (letter_tally[best] > 255) ? 8'hFF : 8'(letter_tally[best]);
                beat.closing = 1'b0;
                fresh_ranking.push_back(beat);
            end
        end
        while (best >= 0);

        if (fresh_ranking.size() == 0)
            fresh_ranking.push_back('{8'h00, 8'h00, 1'b1});
        else
            fresh_ranking[fresh_ranking.size() - 1].closing = 1'b1;

        for (int i = 0; i < NUM_BINS; i++)
            letter_tally[i] = '0;
    endfunction

    // Offer one character, wait for the beat, then record what it should cause
    task automatic send_char(input logic [7:0] c, input logic text_end,
                             input logic typed, input rank_beat_t want);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= text_end;
        do
            @(posedge clk);
        while (!s_axis_tready);
        chars_sent++;
        tally_char(c, text_end);
        if (typed && text_end)
            pending_ranking.push_back(want);
        else
            foreach (fresh_ranking[i])
                pending_ranking.push_back(fresh_ranking[i]);
    endtask

    function automatic logic [7:0] any_letter();
        int v;

        v = $urandom_range(NUM_BINS - 1);
        return (v < HALF_BINS) ? 8'(CHAR_UPPER_A + v) : 8'(CHAR_LOWER_A + v - HALF_BINS);
    endfunction

    // Random text: mostly a few repeated letters for ties, some noise bytes
    task automatic send_random_text();
        int         len;
        int         pick;
        bit         noise_only;
        logic [7:0] pool [4];
        logic [7:0] c;

        noise_only = ($urandom_range(7) == 0);
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        foreach (pool[i])
            pool[i] = any_letter();
        for (int n = 0; n < len; n++)
        begin
            pick = $urandom_range(99);
            if (noise_only || pick >= 80)
            begin
                c = 8'($urandom_range(255));
                // push a letter out of both ranges when the text must stay empty
                if (noise_only && ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                                   (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)))
                    c = c | 8'h80;
            end
            else if (pick < 60)
                c = pool[$urandom_range(3)];
            else
                c = any_letter();
            send_char(c, n == len - 1, 1'b0, '0);
        end
    endtask

    // Every letter once, in shuffled order: the longest ranking
    task automatic send_full_alphabet();
        logic [7:0] codes [NUM_BINS];
        logic [7:0] swap;
        int         j;

        for (int i = 0; i < NUM_BINS; i++)
            codes[i] = (i < HALF_BINS) ? 8'(CHAR_UPPER_A + i)
                                       : 8'(CHAR_LOWER_A + i - HALF_BINS);
        for (int i = NUM_BINS - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            swap = codes[i];
            codes[i] = codes[j];
            codes[j] = swap;
        end
        for (int i = 0; i < NUM_BINS; i++)
            send_char(codes[i], i == NUM_BINS - 1, 1'b0, '0);
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                 $time, field, want, want, got, got);
    endtask

    // Drive output ready; a hold-off request keeps it low for a long stretch
    initial
    begin : rx_ready
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Check each ranking beat against the oldest pending one
    always @(posedge clk)
    begin
        rank_beat_t want;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_ranking.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected beat letter 0x%0h count %0d last %0b",
                         $time, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
            end
            else
            begin
                want = pending_ranking.pop_front();
                if (m_axis_tdata[7:0] !== want.letter)
                    report_mismatch("letter", int'(want.letter),
                                    int'(m_axis_tdata[7:0]));
                if (m_axis_tdata[15:8] !== want.count)
                    report_mismatch("letter_count", int'(want.count),
                                    int'(m_axis_tdata[15:8]));
                if (m_axis_tlast !== want.closing)
                    report_mismatch("last_of_run", int'(want.closing),
                                    int'(m_axis_tlast));
            end
        end
    end

    // Abort when no beat moves on either side for too long
    initial
    begin : watchdog
        int idle_run;

        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("letter_frequency_ranking regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int tx_mix [4];
        int rx_mix [4];
        int phase_start;

        tx_mix = '{0, 53, 0, 22};
        rx_mix = '{0, 0, 53, 22};
        for (int i = 0; i < NUM_BINS; i++)
            letter_tally[i] = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        for (int r = 0; r < NUM_ROWS; r++)
            for (int k = 0; k < DIRECTED_ROWS[r].reps; k++)
                send_char(DIRECTED_ROWS[r].ch,
                          DIRECTED_ROWS[r].text_end && (k == DIRECTED_ROWS[r].reps - 1),
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // hold the output while texts keep coming so the input backs up
        hold_off_req = 1'b1;
        for (int t = 0; t < 4; t++)
            send_random_text();

        // random texts under each idling mix
        for (int p = 0; p < 4; p++)
        begin
            tx_idle_pct  = tx_mix[p];
            rx_stall_pct = rx_mix[p];
            phase_start  = chars_sent;
            if (p == 0)
                send_full_alphabet();
            while (chars_sent - phase_start < PHASE_CHARS)
                send_random_text();
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // drain, then let any stray beat show up
        while (pending_ranking.size() != 0)
            @(posedge clk);
        repeat (2 * (NUM_BINS + 3)) @(posedge clk);

        if (mismatches == 0)
            $display("letter_frequency_ranking regression: pass");
        else
            $display("letter_frequency_ranking regression: fail");
        $finish;
    end

endmodule
